FILE: rtl/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg: shared types and constants of the ordered list store
// Holds the list depth, the derived counter widths, the request and
// result transaction types, and the request and status codes.
// ----------------------------------------------------------------------------
package olst_pkg;

    // Number of cells in the chain (2 to 16).
    localparam int DEPTH = 16;

    // Widths of the fixed transaction fields.
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int FIDX_W   = 4;
    localparam int LEN_W    = 5;

    // Widths that follow from the depth.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request codes.
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // Request transaction.
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_req;

    // Result transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [FIDX_W-1:0]   found_index;
        logic [LEN_W-1:0]    length;
    } t_rsp;

    // Per-cell update controls.
    typedef struct packed {
        logic load;   // take the appended value
        logic shift;  // take the neighbor's value
    } t_cell_ctrl;

endpackage

FILE: rtl/olst_cell.sv
// ----------------------------------------------------------------------------
// olst_cell: one storage cell of the ordered list chain
// Holds one entry, compares it against the search key, and either loads a
// new value or takes the value of its upper neighbor when the gap closes.
// ----------------------------------------------------------------------------
module olst_cell (
    input  logic                                   i_clk,
    input  olst_pkg::t_cell_ctrl                   i_ctrl,
    input  logic signed [olst_pkg::VALUE_W-1:0]    i_new_value,
    input  logic signed [olst_pkg::VALUE_W-1:0]    i_next_value,
    input  logic signed [olst_pkg::VALUE_W-1:0]    i_key,
    output logic signed [olst_pkg::VALUE_W-1:0]    o_value,
    output logic                                   o_eq
);
    import olst_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // Select the next stored value.
    always_comb begin
        n_value = r_value;
        if (i_ctrl.load) begin
            n_value = i_new_value;
        end else if (i_ctrl.shift) begin
            n_value = i_next_value;
        end
    end

    // Entry storage; its contents only matter below the fill count.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Key comparison on the raw bit pattern.
    assign o_eq    = (r_value == i_key);
    assign o_value = r_value;

endmodule

FILE: rtl/ordered_list_store.sv
// A request is accepted into the request register, executed from there, and its
// result is registered in the result register, from which it is offered.
// The single request register holds each request until it executes, so a new
// request is taken only after the last one has executed. A waiting result does not
// block the next acceptance, but a request waits to execute until the result
// register is free. Reset empties the list at once; entry contents are kept.
// ----------------------------------------------------------------------------
// ordered_list_store: ordered list of signed values in a chain of cells
// Serves append, locate and delete-by-position requests; all cells compare in
// parallel, and the cells above a removed entry shift toward the head in one step.
// ----------------------------------------------------------------------------
module ordered_list_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  olst_pkg::t_req   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output olst_pkg::t_rsp   o_out_data
);
    import olst_pkg::*;

    // Control and payload registers.
    logic             r_busy;
    logic             n_busy;
    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic             in_take;
    logic             exec;

    // Chain signals.
    t_cell_ctrl                cell_ctrl [DEPTH];
    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic signed [VALUE_W-1:0] cell_next [DEPTH];
    logic [DEPTH-1:0]          cell_eq;
    logic [DEPTH-1:0]          hit;

    logic [CMP_W-1:0]          count_w;
    logic [CMP_W-1:0]          del_w;
    logic                      del_ok;
    logic                      is_full;
    logic                      any_hit;
    logic [IDX_W-1:0]          hit_idx;

    // Handshake: one request in flight; execution needs a free result slot.
    assign o_in_stall = r_busy;
    assign in_take    = i_in_valid && !r_busy;
    assign exec       = r_busy && (!r_out_valid || !i_out_stall);

    // Delete position (0 acts as 1) and range checks.
    assign count_w = CMP_W'(r_count);
    assign del_w   = (r_req.position == '0) ? '0 : CMP_W'(r_req.position - 1'b1);
    assign del_ok  = (del_w < count_w);
    assign is_full = (r_count >= CNT_W'(DEPTH));

    // Per-cell controls and neighbor links.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].load  = exec && (r_req.op == OP_APPEND) && !is_full
                                 && (CNT_W'(i) == r_count);
            cell_ctrl[i].shift = exec && (r_req.op == OP_DELETE) && del_ok
                                 && (CMP_W'(i) >= del_w)
                                 && (CMP_W'(i + 1) < count_w);
            cell_next[i]       = (i + 1 < DEPTH) ? cell_value[(i + 1) % DEPTH] : '0;
            hit[i]             = cell_eq[i] && (CNT_W'(i) < r_count);
        end
    end

    // The chain of cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        olst_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl[g]),
            .i_new_value  (r_req.value),
            .i_next_value (cell_next[g]),
            .i_key        (r_req.value),
            .o_value      (cell_value[g]),
            .o_eq         (cell_eq[g])
        );
    end

    // First matching cell wins.
    always_comb begin
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end
    assign any_hit = |hit;

    // Request execution: new count and result transaction.
    always_comb begin
        n_count           = r_count;
        n_rsp             = r_rsp;
        n_out_valid       = r_out_valid && i_out_stall;
        n_busy            = r_busy;
        if (exec) begin
            n_busy             = 1'b0;
            n_out_valid        = 1'b1;
            n_rsp.status       = ST_OK;
            n_rsp.found        = 1'b0;
            n_rsp.found_index  = '0;
            case (r_req.op)
                OP_APPEND: begin
                    if (is_full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                OP_LOCATE: begin
                    if (any_hit) begin
                        n_rsp.found       = 1'b1;
                        n_rsp.found_index = FIDX_W'(hit_idx);
                    end else begin
                        n_rsp.status = ST_NOTFOUND;
                    end
                end
                OP_DELETE: begin
                    if (r_count == '0) begin
                        n_rsp.status = ST_EMPTY;
                    end else if (!del_ok) begin
                        n_rsp.status = ST_BADPOS;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    n_rsp.status = ST_OK;
                end
            endcase
            n_rsp.length = LEN_W'(n_count);
        end
        if (in_take) begin
            n_busy = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req <= i_in_data;
        end
        r_rsp <= n_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_rsp;

endmodule

FILE: verif/ordered_list_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_tb: self-checking testbench of the ordered list store
// Drives append, locate, delete and unused-code requests through the valid/stall request
// channel. A scoreboard mirrors the list contents and predicts each result,
// and a monitor checks every result transaction in order. Random idle and
// stall phases vary the pressure on both sides of the block.
// ----------------------------------------------------------------------------
module ordered_list_store_tb;

    import olst_pkg::*;

    // Request code that the block answers without touching the list.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 250;

    // Mirror of the list plus the queue of results still owed by the block.
    class list_scoreboard;
        logic [VALUE_W-1:0] entries [DEPTH];
        int                 count;
        t_rsp               expected_q [$];
        int                 mismatches;
        int                 checked;
        int                 op_count [4];
        int                 status_count [8];

        // Prints one line for a mismatch and counts it.
        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Applies one accepted request to the mirror and queues its result.
        task note_request(t_req req);
            t_rsp rsp;
            int   del;
            rsp = '0;
            case (req.op)
                OP_APPEND: begin
                    if (count >= DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        entries[count] = req.value;
                        count++;
                    end
                end
                OP_LOCATE: begin
                    // Scan from the tail so the lowest matching index wins.
                    rsp.status = ST_NOTFOUND;
                    for (int i = count - 1; i >= 0; i--) begin
                        if (entries[i] == req.value) begin
                            rsp.status      = ST_OK;
                            rsp.found       = 1'b1;
                            rsp.found_index = FIDX_W'(i);
                        end
                    end
                end
                OP_DELETE: begin
                    del = (req.position == '0) ? 0 : int'(req.position) - 1;
                    if (count == 0) begin
                        rsp.status = ST_EMPTY;
                    end else if (del >= count) begin
                        rsp.status = ST_BADPOS;
                    end else begin
                        for (int i = del; i + 1 < count; i++) begin
                            entries[i] = entries[i + 1];
                        end
                        count--;
                    end
                end
                default: begin
                end
            endcase
            rsp.length = LEN_W'(count);
            op_count[req.op]++;
            status_count[rsp.status]++;
            expected_q.push_back(rsp);
        endtask

        // Compares one result transaction with the oldest expectation.
        task check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = expected_q.pop_front();
                checked++;
                if (got.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              checked, got.status, want.status));
                if (got.found !== want.found)
                    report_mismatch($sformatf("result %0d found %0d, want %0d",
                                              checked, got.found, want.found));
                if (got.found_index !== want.found_index)
                    report_mismatch($sformatf("result %0d found_index %0d, want %0d",
                                              checked, got.found_index,
                                              want.found_index));
                if (got.length !== want.length)
                    report_mismatch($sformatf("result %0d length %0d, want %0d",
                                              checked, got.length, want.length));
            end
        endtask
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_req in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_rsp out_data;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    list_scoreboard sb = new();

    ordered_list_store DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Clock generation.
    initial begin
        forever #6 clk = ~clk;
    end

    // Hard limit on the run time.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Builds one request transaction.
    function automatic t_req make_req(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                      logic [POS_W-1:0] position);
        t_req req;
        req.op       = op;
        req.value    = value;
        req.position = position;
        return req;
    endfunction

    // Values that tend to repeat, so that locate sees duplicates and extremes.
    function automatic logic [VALUE_W-1:0] pool_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h5555_5555;
            6: return 32'hAAAA_AAAA;
            default: return 32'd42;
        endcase
    endfunction

    // Draws a random request, mostly appends while growing, mostly deletes
    // while shrinking, with keys and positions aimed at the current contents.
    function automatic t_req draw_request(bit growing);
        t_req req;
        int   pick;
        int   n;
        n            = sb.count;
        pick         = $urandom_range(99);
        req.value    = ($urandom_range(1) == 0) ? pool_value() : $urandom;
        req.position = POS_W'($urandom_range(31));
        if (pick < (growing ? 55 : 15))
            req.op = OP_APPEND;
        else if (pick < (growing ? 80 : 40))
            req.op = OP_LOCATE;
        else if (pick < 95)
            req.op = OP_DELETE;
        else
            req.op = OP_UNUSED;

        pick = $urandom_range(99);
        if (req.op == OP_LOCATE && n > 0 && pick < 50) begin
            req.value = sb.entries[$urandom_range(n - 1)];
        end else if (req.op == OP_DELETE && pick >= 25) begin
            req.position = POS_W'($urandom_range(n + 1, 1));
        end else if (req.op == OP_DELETE && pick >= 15) begin
            req.position = '0;
        end
        return req;
    endfunction

    // Offers one request after a random gap and waits for its acceptance.
    task automatic drive_request(t_req req);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        sb.note_request(req);
    endtask

    // Result monitor with random back-pressure.
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                sb.check_result(out_data);
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Stimulus: directed corner cases, then random phases with varied idling.
    initial begin
        bit growing;
        growing = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: delete, locate and the unused code.
        drive_request(make_req(OP_DELETE, 32'd0, 5'd1));
        drive_request(make_req(OP_LOCATE, 32'd7, 5'd0));
        drive_request(make_req(OP_UNUSED, 32'hFFFF_FFFF, 5'd31));

        // Fill to capacity with extremes first and a duplicate later on.
        drive_request(make_req(OP_APPEND, 32'h8000_0000, 5'd0));
        drive_request(make_req(OP_APPEND, 32'h7FFF_FFFF, 5'd0));
        drive_request(make_req(OP_APPEND, 32'h0000_0000, 5'd0));
        drive_request(make_req(OP_APPEND, 32'hFFFF_FFFF, 5'd0));
        for (int k = 4; k < DEPTH; k++) begin
            drive_request(make_req(OP_APPEND,
                                   (k == DEPTH - 6) ? 32'hFFFF_FFFF : 32'h1000_0000 + k,
                                   5'd0));
        end

        // Full list: append refused, locate last entry, first duplicate and a refused value.
        drive_request(make_req(OP_APPEND, 32'h1234_5678, 5'd0));
        drive_request(make_req(OP_LOCATE, sb.entries[DEPTH - 1], 5'd0));
        drive_request(make_req(OP_LOCATE, 32'hFFFF_FFFF, 5'd0));
        drive_request(make_req(OP_LOCATE, 32'h1234_5678, 5'd0));

        // Deletes: beyond the length, the last entry, and position zero.
        drive_request(make_req(OP_DELETE, 32'd0, 5'd31));
        drive_request(make_req(OP_DELETE, 32'd0, POS_W'(DEPTH)));
        drive_request(make_req(OP_DELETE, 32'd0, 5'd0));
        drive_request(make_req(OP_UNUSED, 32'h0000_0000, 5'd0));

        // Random phases: none, sender idle, receiver stall, both.
        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = (phase == 1) ? 64 : (phase == 3) ? 23 : 0;
            receiver_stall_pct = (phase == 2) ? 64 : (phase == 3) ? 23 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (sb.count >= DEPTH && $urandom_range(2) == 0)
                    growing = 1'b0;
                else if (sb.count == 0 && $urandom_range(2) == 0)
                    growing = 1'b1;
                drive_request(draw_request(growing));
            end
        end
        in_valid <= 1'b0;

        // Drain the outstanding results, then watch for stray ones.
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d appends, %0d locates, %0d deletes and %0d unused codes.",
                 sb.op_count[OP_APPEND], sb.op_count[OP_LOCATE],
                 sb.op_count[OP_DELETE], sb.op_count[OP_UNUSED]);
        $display("Checked %0d results: full %0d, empty %0d, bad position %0d, miss %0d.",
                 sb.checked, sb.status_count[ST_FULL], sb.status_count[ST_EMPTY],
                 sb.status_count[ST_BADPOS], sb.status_count[ST_NOTFOUND]);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/olst_pkg.sv
rtl/olst_cell.sv
rtl/ordered_list_store.sv
verif/ordered_list_store_tb.sv
